FILE: rtl/tcprc_pkg.sv
// Shared types, codes and helpers for the Reno congestion controller.
package tcprc_pkg;

  localparam int SDataW = 64;
  localparam int MDataW = 152;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CFG_MSS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOTAL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_THR   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RTT   = 2'd3;

  localparam logic [1:0] CLS_NEW     = 2'd0;
  localparam logic [1:0] CLS_DUP     = 2'd1;
  localparam logic [1:0] CLS_STALE   = 2'd2;
  localparam logic [1:0] CLS_TIMEOUT = 2'd3;

  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_NEXT = 2'd1;
  localparam logic [1:0] SEND_RETX = 2'd2;

  localparam logic [1:0] PH_SS = 2'd0;
  localparam logic [1:0] PH_CA = 2'd1;
  localparam logic [1:0] PH_FR = 2'd2;

  localparam logic       ACT_ACK   = 1'b0;
  localparam logic       ACT_EXPIRY = 1'b1;

  localparam logic [15:0] RST_MSS = 16'd1472;
  localparam logic [31:0] RST_THR = 32'd64000;
  localparam logic [15:0] RST_RTT = 16'd20;
  localparam logic [2:0]  DUP_LIMIT = 3'd3;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] sat32(input logic [32:0] v);
    sat32 = v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

FILE: rtl/tcp_reno_congestion_control_core.sv
// Top level of the sender-side Reno congestion controller.
// One transaction on the slave side (an ack with its RTT sample, or a timer
// expiry) yields exactly one result transaction on the master side. An ack or
// expiry that needs no window division goes from the prepare state to the
// done state, where its result is committed to the output register; the next
// transaction is accepted once the controller is back in idle. A new ack in
// slow start or avoidance with the window at or above the threshold first
// runs the mss*mss/cwnd division through a 32-step serial divider. Without
// stalls on the master side, the serial divider sets the worst-case rate. The
// input is taken only while no item is in flight, but a finished result may
// still wait on the master side while the next transaction is accepted; the
// commit of that next result then holds until the waiting one is taken.
// A configuration write is ignored at a commit edge; issue writes only while
// idle.
module tcp_reno_congestion_control_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [tcprc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tcprc_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // ack_number [47:0], rtt_sample [63:48]
  input  logic [tcprc_pkg::SDataW-1:0]   s_tdata,
  // action [0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // send_action [1:0], phase [3:2], window [35:4], threshold [67:36],
  // timeout_value [99:68], acked_up_to [147:100], done_res [148], zero [151:149]
  output logic [tcprc_pkg::MDataW-1:0]   m_tdata,
  // ack_class [1:0]
  output logic [1:0]                     m_tuser
);

  tcprc_pkg::cmd_t cmd;
  tcprc_pkg::sts_t sts;

  tcprc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcprc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("result committed over a waiting result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a transaction is in flight");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[35:4] != 32'd0))
    else $error("window reported as zero");

endmodule

FILE: rtl/tcprc_div.sv
// Restoring serial divider, one quotient bit per cycle.
module tcprc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  localparam int DivBits = 32;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_next;

  assign rem_sh   = {rem, quo[31]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_next = ge ? rem_sh - {1'b0, dvs} : rem_sh;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DivBits);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next[31:0];
      quo <= {quo[30:0], ge};
    end
  end

endmodule

FILE: rtl/tcprc_dp.sv
// Datapath: configuration, Reno state, RTT estimator and result register.
module tcprc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [tcprc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tcprc_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic [tcprc_pkg::SDataW-1:0]  s_tdata,
  input  logic                          s_tuser,
  input  tcprc_pkg::cmd_t               cmd,
  output tcprc_pkg::sts_t               sts,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tcprc_pkg::MDataW-1:0]  m_tdata,
  output logic [1:0]                    m_tuser
);

  logic [15:0] mss_cfg;
  logic [47:0] total;
  logic [1:0]  phase;
  logic [31:0] cwnd;
  logic [31:0] ssthresh;
  logic [1:0]  dup;
  logic [47:0] last_ack;
  logic [15:0] est;
  logic [15:0] dev;
  logic [31:0] rto;

  logic        in_action;
  logic [47:0] in_ack;
  logic [15:0] in_rtt;
  logic [31:0] prod;

  logic [15:0] mss_eff;
  logic [48:0] expected;
  logic [47:0] exp_cap;
  logic        is_new;
  logic        is_dup;
  logic [31:0] half;
  logic [17:0] mss3;
  logic [19:0] sum7;
  logic [15:0] est_upd;
  logic [15:0] diff;
  logic [17:0] sum3;
  logic [15:0] dev_upd;
  logic [31:0] rto_upd;
  logic        div_done;
  logic [31:0] quo;
  logic [31:0] divisor;

  logic [1:0]  cls;
  logic [1:0]  send;
  logic [1:0]  phase_next;
  logic [31:0] cwnd_next;
  logic [31:0] ssthresh_next;
  logic [1:0]  dup_next;
  logic [47:0] last_ack_next;
  logic [15:0] est_next;
  logic [15:0] dev_next;
  logic [31:0] rto_next;
  logic        done_next;

  assign mss_eff  = (mss_cfg == 16'd0) ? 16'd1 : mss_cfg;
  assign expected = {1'b0, last_ack} + {33'd0, mss_eff};
  assign exp_cap  = (expected > {1'b0, total}) ? total : expected[47:0];
  assign is_new   = in_ack >= exp_cap;
  assign is_dup   = in_ack == last_ack;
  assign half     = (cwnd[31:1] == 31'd0) ? 32'd1 : {1'b0, cwnd[31:1]};
  assign mss3     = {2'b00, mss_eff} + {1'b0, mss_eff, 1'b0};

  assign sum7    = {1'b0, est, 3'b000} - {4'd0, est} + {4'd0, in_rtt};
  assign est_upd = sum7[18:3];
  assign diff    = (in_rtt >= est_upd) ? in_rtt - est_upd : est_upd - in_rtt;
  assign sum3    = {2'b00, dev} + {1'b0, dev, 1'b0} + {2'b00, diff};
  assign dev_upd = sum3[17:2];
  assign rto_upd = {16'd0, est_upd} + {14'd0, dev_upd, 2'b00};

  assign divisor = (cwnd == 32'd0) ? 32'd1 : cwnd;

  tcprc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (prod),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  assign sts.need_div = (in_action == tcprc_pkg::ACT_ACK) && is_new &&
                        (phase != tcprc_pkg::PH_FR) && !(cwnd < ssthresh);
  assign sts.div_done = div_done;
  assign sts.out_busy = m_tvalid && !m_tready;

  always_comb begin
    cls           = tcprc_pkg::CLS_STALE;
    send          = tcprc_pkg::SEND_NONE;
    phase_next    = phase;
    cwnd_next     = cwnd;
    ssthresh_next = ssthresh;
    dup_next      = dup;
    last_ack_next = last_ack;
    est_next      = est;
    dev_next      = dev;
    rto_next      = rto;
    if (in_action == tcprc_pkg::ACT_EXPIRY) begin
      cls           = tcprc_pkg::CLS_TIMEOUT;
      ssthresh_next = half;
      cwnd_next     = {16'd0, mss_eff};
      dup_next      = 2'd0;
      phase_next    = tcprc_pkg::PH_SS;
      rto_next      = tcprc_pkg::sat32({rto, 1'b0});
      send          = tcprc_pkg::SEND_RETX;
    end else if (is_new) begin
      cls           = tcprc_pkg::CLS_NEW;
      last_ack_next = in_ack;
      est_next      = est_upd;
      dev_next      = dev_upd;
      rto_next      = rto_upd;
      dup_next      = 2'd0;
      if (phase == tcprc_pkg::PH_FR) begin
        cwnd_next  = ssthresh;
        phase_next = tcprc_pkg::PH_CA;
      end else begin
        if (cwnd < ssthresh) begin
          cwnd_next = tcprc_pkg::sat32({1'b0, cwnd} + {17'd0, mss_eff});
        end else begin
          cwnd_next = tcprc_pkg::sat32({1'b0, cwnd} + {1'b0, quo});
        end
        phase_next = (cwnd_next >= ssthresh) ? tcprc_pkg::PH_CA : tcprc_pkg::PH_SS;
        send       = tcprc_pkg::SEND_NEXT;
      end
    end else if (is_dup) begin
      cls = tcprc_pkg::CLS_DUP;
      if (phase == tcprc_pkg::PH_FR) begin
        cwnd_next = tcprc_pkg::sat32({1'b0, cwnd} + {17'd0, mss_eff});
        send      = tcprc_pkg::SEND_NEXT;
      end else begin
        dup_next = dup + 2'd1;
        if ({1'b0, dup_next} == tcprc_pkg::DUP_LIMIT) begin
          ssthresh_next = half;
          cwnd_next     = tcprc_pkg::sat32({1'b0, half} + {15'd0, mss3});
          phase_next    = tcprc_pkg::PH_FR;
          send          = tcprc_pkg::SEND_RETX;
        end
      end
    end
  end

  assign done_next = last_ack_next >= total;

  always_ff @(posedge clk) begin
    if (rst) begin
      mss_cfg  <= tcprc_pkg::RST_MSS;
      total    <= '0;
      phase    <= tcprc_pkg::PH_SS;
      cwnd     <= {16'd0, tcprc_pkg::RST_MSS};
      ssthresh <= tcprc_pkg::RST_THR;
      dup      <= 2'd0;
      last_ack <= 48'd1;
      est      <= tcprc_pkg::RST_RTT;
      dev      <= 16'd0;
      rto      <= 32'd1;
    end else if (cmd.commit) begin
      phase    <= phase_next;
      cwnd     <= cwnd_next;
      ssthresh <= ssthresh_next;
      dup      <= dup_next;
      last_ack <= last_ack_next;
      est      <= est_next;
      dev      <= dev_next;
      rto      <= rto_next;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tcprc_pkg::CFG_MSS: begin
          mss_cfg <= cfg_wdata[15:0];
          cwnd    <= (cfg_wdata[15:0] == 16'd0) ? 32'd1 : {16'd0, cfg_wdata[15:0]};
        end
        tcprc_pkg::CFG_TOTAL: begin
          total <= cfg_wdata;
        end
        tcprc_pkg::CFG_THR: begin
          ssthresh <= (cfg_wdata[31:0] == 32'd0) ? 32'd1 : cfg_wdata[31:0];
        end
        tcprc_pkg::CFG_RTT: begin
          est <= cfg_wdata[15:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_action <= s_tuser;
      in_ack    <= s_tdata[47:0];
      in_rtt    <= s_tdata[63:48];
      prod      <= {16'd0, mss_eff} * {16'd0, mss_eff};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tuser <= cls;
      m_tdata <= {3'd0, done_next, last_ack_next, rto_next, ssthresh_next, cwnd_next,
                  phase_next, send};
    end
  end

endmodule

FILE: rtl/tcprc_ctrl.sv
// Controller: sequences accept, divide and commit of one transaction.
module tcprc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  tcprc_pkg::sts_t sts,
  output tcprc_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next    = state;
    cmd.load_in   = 1'b0;
    cmd.start_div = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.need_div) begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
